// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative cache tag directory.
// Used by sacl_ctrl, sacl_dp and set_assoc_cache_lru; depends on nothing.
package sacl_pkg;

    localparam int ADDR_W    = 32;
    localparam int OFFSET_W  = 4;
    localparam int HIT_WAY_W = 2;
    localparam int COUNT_W   = 32;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd6;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic split_step;
        logic mem_rd;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic split_done;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/sacl_ctrl.sv =====
// Controller state machine of the cache tag directory.
// Depends on sacl_pkg for the command and status structs.
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;
    localparam logic [1:0] ST_LOOK  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (status.split_done)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_LOOK;
                end
                else
                begin
                    cmd.split_step = 1'b1;
                end
            end
            ST_LOOK:
            begin
                // The set row is read; write it back once the result register is free.
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== rtl/sacl_dp.sv =====
// Datapath of the cache tag directory: address split, set memory, LRU update,
// counters and result register. Depends on sacl_pkg for types and constants.
module sacl_dp
    import sacl_pkg::*;
#(
    parameter int WAYS      = 4,
    parameter int SETS      = 64,
    parameter int ADDR_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [OFFSET_W-1:0]   cfg_wdata,
    input  logic [ADDR_W-1:0]     address,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [HIT_WAY_W-1:0]  hit_way,
    output logic [COUNT_W-1:0]    access_total,
    output logic [COUNT_W-1:0]    miss_total
);

    localparam int AW      = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int SET_LOG = $clog2(SETS);
    localparam int SET_W   = (SETS > 1) ? SET_LOG : 1;
    localparam int FLOG    = $clog2(SETS + 1) - 1;
    localparam int TAG_W   = (AW > FLOG) ? (AW - FLOG) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W   = WAY_W;
    localparam bit SETS_POW2 = ((1 << SET_LOG) == SETS);

    logic [OFFSET_W-1:0] offset_reg;
    logic [AW-1:0]       block_in;
    logic [SET_W-1:0]    set_idx;
    logic [TAG_W-1:0]    tag_cur;
    logic                split_done;

    logic [SET_W-1:0]    clear_cnt_reg;

    logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SETS];
    logic [WAYS-1:0]            valid_mem [SETS];
    logic [WAYS-1:0][AGE_W-1:0] age_mem   [SETS];

    logic [WAYS-1:0][TAG_W-1:0] rd_tag_reg;
    logic [WAYS-1:0]            rd_valid_reg;
    logic [WAYS-1:0][AGE_W-1:0] rd_age_reg;

    logic [WAYS-1:0][TAG_W-1:0] wr_tag;
    logic [WAYS-1:0]            wr_valid;
    logic [WAYS-1:0][AGE_W-1:0] wr_age;
    logic [WAYS-1:0][TAG_W-1:0] new_tag;
    logic [WAYS-1:0]            new_valid;
    logic [WAYS-1:0][AGE_W-1:0] new_age;
    logic [WAYS-1:0][AGE_W-1:0] init_age;
    logic [SET_W-1:0]           wr_idx;
    logic                       mem_we;

    logic                hit_found;
    logic                inv_found;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    inv_idx;
    logic [WAY_W-1:0]    old_idx;
    logic [WAY_W-1:0]    way_sel;
    logic [AGE_W-1:0]    old_age;

    logic                out_valid_reg;
    logic                hit_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [COUNT_W-1:0]  access_reg;
    logic [COUNT_W-1:0]  miss_reg;

    // Offset width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            offset_reg <= cfg_wdata;
        end
    end

    assign block_in = address[AW-1:0] >> offset_reg;

    // Split of the block number into set index and tag.
    generate
        if (SETS_POW2)
        begin : g_split_pow2
            logic [AW-1:0] blk_reg;
            logic [AW-1:0] blk_shift;

            always_ff @(posedge clk)
            begin
                if (cmd.capture)
                begin
                    blk_reg <= block_in;
                end
            end

            assign blk_shift  = blk_reg >> SET_LOG;
            assign tag_cur    = blk_shift[TAG_W-1:0];
            assign set_idx    = blk_reg[SET_W-1:0] & SET_W'(SETS - 1);
            assign split_done = 1'b1;
        end
        else
        begin : g_split_div
            // Division by SETS as a multiply by a rounded-up reciprocal, in three
            // steps: two half-width partial products, their sum and shift, and
            // the remainder from the low bits of block - quotient * SETS.
            localparam int          LO_W   = AW / 2;
            localparam int          HI_W   = AW - LO_W;
            localparam int          RCP_W  = AW + 1;
            localparam int          PROD_W = 2 * AW + 1;
            localparam logic [63:0] RCP    = ((64'd1 << (AW + SET_LOG)) / 64'(SETS)) + 64'd1;
            localparam logic [RCP_W-1:0] RCP_V = RCP[RCP_W-1:0];

            logic [AW-1:0]           n_reg;
            logic [HI_W+RCP_W-1:0]   p_hi_reg;
            logic [LO_W+RCP_W-1:0]   p_lo_reg;
            logic [PROD_W-1:0]       prod;
            logic [AW-1:0]           q_reg;
            logic [SET_W-1:0]        rem_reg;
            logic [SET_W-1:0]        q_times_d;
            logic [1:0]              step_reg;

            assign prod      = (PROD_W'(p_hi_reg) << LO_W) + PROD_W'(p_lo_reg);
            assign q_times_d = SET_W'(q_reg) * SET_W'(SETS);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= '0;
                end
                else if (cmd.capture)
                begin
                    step_reg <= '0;
                end
                else if (cmd.split_step)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.capture)
                begin
                    n_reg <= block_in;
                end
                else if (cmd.split_step)
                begin
                    unique case (step_reg)
                        2'd0:
                        begin
                            p_lo_reg <= (LO_W + RCP_W)'(n_reg[LO_W-1:0])
                                        * (LO_W + RCP_W)'(RCP_V);
                            p_hi_reg <= (HI_W + RCP_W)'(n_reg[AW-1:LO_W])
                                        * (HI_W + RCP_W)'(RCP_V);
                        end
                        2'd1:
                        begin
                            q_reg <= AW'(prod >> (AW + SET_LOG));
                        end
                        2'd2:
                        begin
                            rem_reg <= SET_W'(n_reg) - q_times_d;
                        end
                        2'd3:
                        begin
                        end
                    endcase
                end
            end

            assign tag_cur    = q_reg[TAG_W-1:0];
            assign set_idx    = rem_reg;
            assign split_done = (step_reg == 2'd3);
        end
    endgenerate

    // Clearing pass over the sets after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Lookup, victim choice and age update for the set row just read.
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        inv_found = 1'b0;
        inv_idx   = '0;
        old_idx   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && rd_valid_reg[w] && (rd_tag_reg[w] == tag_cur))
            begin
                hit_found = 1'b1;
                hit_idx   = WAY_W'(w);
            end
            if (!inv_found && !rd_valid_reg[w])
            begin
                inv_found = 1'b1;
                inv_idx   = WAY_W'(w);
            end
            // Ages form a permutation, so exactly one way holds the oldest age.
            if (rd_age_reg[w] == AGE_W'(WAYS - 1))
            begin
                old_idx = WAY_W'(w);
            end
        end

        priority if (hit_found)
        begin
            way_sel = hit_idx;
        end
        else if (inv_found)
        begin
            way_sel = inv_idx;
        end
        else
        begin
            way_sel = old_idx;
        end

        old_age   = rd_age_reg[way_sel];
        new_tag   = rd_tag_reg;
        new_valid = rd_valid_reg;
        if (!hit_found)
        begin
            new_tag[way_sel]   = tag_cur;
            new_valid[way_sel] = 1'b1;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            new_age[w]  = (rd_age_reg[w] < old_age) ? rd_age_reg[w] + 1'b1 : rd_age_reg[w];
            init_age[w] = AGE_W'(w);
        end
        new_age[way_sel] = '0;
    end

    assign mem_we   = cmd.clear_wr | cmd.commit;
    assign wr_idx   = cmd.clear_wr ? clear_cnt_reg : set_idx;
    assign wr_tag   = cmd.clear_wr ? '0 : new_tag;
    assign wr_valid = cmd.clear_wr ? '0 : new_valid;
    assign wr_age   = cmd.clear_wr ? init_age : new_age;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[wr_idx]   <= wr_tag;
            valid_mem[wr_idx] <= wr_valid;
            age_mem[wr_idx]   <= wr_age;
        end
        if (cmd.mem_rd)
        begin
            rd_tag_reg   <= tag_mem[set_idx];
            rd_valid_reg <= valid_mem[set_idx];
            rd_age_reg   <= age_mem[set_idx];
        end
    end

    // Counters double as the count fields of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            access_reg    <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (access_reg != COUNT_MAX)
                begin
                    access_reg <= access_reg + 1'b1;
                end
                if (!hit_found && (miss_reg != COUNT_MAX))
                begin
                    miss_reg <= miss_reg + 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg <= hit_found;
            way_reg <= way_sel;
        end
    end

    assign status.clear_last = (clear_cnt_reg == SET_W'(SETS - 1));
    assign status.split_done = split_done;
    assign status.out_busy   = out_valid_reg & out_stall;

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_way      = HIT_WAY_W'(way_reg);
    assign access_total = access_reg;
    assign miss_total   = miss_reg;

endmodule

// ===== rtl/set_assoc_cache_lru.sv =====
// Top level of the set-associative cache tag directory with true LRU.
// Depends on sacl_pkg, sacl_ctrl and sacl_dp.
//
// Input channel: in_valid / in_stall with the byte address. Output channel:
// out_valid / out_stall with hit, hit_way, access_total and miss_total, one
// result beat per input beat, in order.
// Configuration: cfg_we writes cfg_wdata into the offset width register; the
// directory contents are not disturbed by a write.
// Each access reads its set row from memory, compares all ways, and writes the
// updated row back: one item is worked at a time. With a power-of-two SETS the
// set/tag split is a mask and shift; otherwise it is a reciprocal multiply
// done in the split steps before the set row is read. A new beat is accepted
// only after the write-back, which also loads the result register.
// After reset the block sweeps all SETS rows, one per cycle, clearing valid
// bits and setting ages to the way number; in_stall stays high during the
// sweep. Counters and the offset register (6) are reset at once.
// A result waits in the output register while out_stall is high, and the next
// beat is still accepted; that beat's write-back waits until the result leaves.
module set_assoc_cache_lru
    import sacl_pkg::*;
#(
    parameter int WAYS      = 4,
    parameter int SETS      = 64,
    parameter int ADDR_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [OFFSET_W-1:0]   cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ADDR_W-1:0]     address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [HIT_WAY_W-1:0]  hit_way,
    output logic [COUNT_W-1:0]    access_total,
    output logic [COUNT_W-1:0]    miss_total
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sacl_dp #(
        .WAYS      (WAYS),
        .SETS      (SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .address      (address),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_way      (hit_way),
        .access_total (access_total),
        .miss_total   (miss_total)
    );

endmodule
